### rtl/gfli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfli_pkg: shared types and constants
// Types and constants for the GF(2^32) Lagrange interpolator.
// ----------------------------------------------------------------------------
package gfli_pkg;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned DefMaxPoints = 16;
  localparam logic [FieldWidth-1:0] ModulusReset = 32'd141;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;

  typedef struct packed {
    logic [1:0]            operation;
    logic [FieldWidth-1:0] point_x;
    logic [FieldWidth-1:0] point_y;
    logic [FieldWidth-1:0] position;
  } gfli_in_t;

  typedef struct packed {
    logic [FieldWidth-1:0] value;
    logic                  duplicate_nodes;
    logic                  overflowed;
  } gfli_out_t;
endpackage
`default_nettype wire

### rtl/gfli_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfli_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gfli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

### rtl/gfli_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfli_mul: bit-serial GF(2^32) multiplier
// Multiplies two field elements one bit of b per cycle, most significant
// bit first, with interleaved reduction.
// ----------------------------------------------------------------------------
module gfli_mul
  import gfli_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [FieldWidth-1:0] a,
  input  wire logic [FieldWidth-1:0] b,
  input  wire logic [FieldWidth-1:0] modulus,
  output      logic                  done,
  output      logic [FieldWidth-1:0] product
);
  localparam int unsigned CntW = $clog2(FieldWidth + 1);

  logic [FieldWidth-1:0] a_r, b_r, p_r, p_nxt, sh;
  logic [CntW-1:0]       cnt_r;
  logic                  busy_r;

  always_comb begin
    sh    = {p_r[FieldWidth-2:0], 1'b0} ^ (p_r[FieldWidth-1] ? modulus : '0);
    p_nxt = sh ^ (b_r[FieldWidth-1] ? a_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(FieldWidth);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= p_nxt;
      b_r <= {b_r[FieldWidth-2:0], 1'b0};
    end
  end

  assign product = p_r;
endmodule
`default_nettype wire

### rtl/gf2_32_lagrange_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf2_32_lagrange_interpolator: Lagrange interpolation over GF(2^32)
// Stores up to MAX_POINTS points and evaluates the interpolating polynomial
// with barycentric weights, using one shared bit-serial multiplier.
// Clear and load finish in state S_WRD. Evaluate first refreshes the weights
// if a load or clear came since the last refresh, then sums one term per stored
// point; every multiply holds the single serial multiplier until it is done.
// A result waits in an output register; input stalls while any request is processed.
// Synchronous active-low reset empties the store and sets the modulus to 141.
// ----------------------------------------------------------------------------
module gf2_32_lagrange_interpolator
  import gfli_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DefMaxPoints
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire gfli_in_t              in_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      gfli_out_t             out_data,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [FieldWidth-1:0] cfg_data
);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned KW = 5;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WI    = 4'd1;
  localparam logic [3:0] S_WJ    = 4'd2;
  localparam logic [3:0] S_WJD   = 4'd3;
  localparam logic [3:0] S_WMUL  = 4'd4;
  localparam logic [3:0] S_INV   = 4'd5;
  localparam logic [3:0] S_INVW  = 4'd6;
  localparam logic [3:0] S_EI    = 4'd7;
  localparam logic [3:0] S_EJ    = 4'd8;
  localparam logic [3:0] S_EJD   = 4'd9;
  localparam logic [3:0] S_EMUL  = 4'd10;
  localparam logic [3:0] S_EY    = 4'd11;
  localparam logic [3:0] S_EYW   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;
  localparam logic [3:0] S_WRD   = 4'd14;

  logic [3:0]            state_r;
  logic [FieldWidth-1:0] modulus_r;
  logic [CW-1:0]         count_r;
  logic                  cur_r, dup_r, ovf_r;
  logic [CW-1:0]         i_r, j_r;
  logic [FieldWidth-1:0] t_r, sq_r, r_r, xi_r, acc_r, pos_r;
  logic [KW-1:0]         k_r;
  logic                  ph_r;
  gfli_in_t              req_r;
  logic                  out_valid_r;
  gfli_out_t             out_res_r;
  logic                  out_load;

  logic                  m_start, m_done;
  logic [FieldWidth-1:0] m_a, m_b, m_p;

  logic                  x_we, y_we, w_we;
  logic [AW-1:0]         x_ra, y_ra, w_ra, waddr;
  logic [FieldWidth-1:0] x_rd, y_rd, w_rd, w_wd;

  gfli_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
    .modulus(modulus_r), .done(m_done), .product(m_p)
  );

  gfli_ram #(.WIDTH(FieldWidth), .DEPTH(MAX_POINTS)) u_xram (
    .clk(clk), .we(x_we), .waddr(waddr), .wdata(req_r.point_x),
    .raddr(x_ra), .rdata(x_rd)
  );
  gfli_ram #(.WIDTH(FieldWidth), .DEPTH(MAX_POINTS)) u_yram (
    .clk(clk), .we(y_we), .waddr(waddr), .wdata(req_r.point_y),
    .raddr(y_ra), .rdata(y_rd)
  );
  gfli_ram #(.WIDTH(FieldWidth), .DEPTH(MAX_POINTS)) u_wram (
    .clk(clk), .we(w_we), .waddr(i_r[AW-1:0]), .wdata(w_wd),
    .raddr(w_ra), .rdata(w_rd)
  );

  logic load_ok;
  assign load_ok = (count_r < CW'(MAX_POINTS));
  assign waddr   = count_r[AW-1:0];
  assign x_we    = (state_r == S_WRD) && (req_r.operation == OP_LOAD) && load_ok;
  assign y_we    = x_we;
  assign x_ra    = (state_r == S_WI || state_r == S_EI) ? i_r[AW-1:0] : j_r[AW-1:0];
  assign y_ra    = i_r[AW-1:0];
  assign w_ra    = i_r[AW-1:0];
  assign w_we    = (state_r == S_INVW) && m_done && ph_r && (k_r == KW'(31));
  assign w_wd    = m_p;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_res_r   <= '{value: acc_r, duplicate_nodes: dup_r, overflowed: ovf_r};
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    m_start = 1'b0;
    m_a     = t_r;
    m_b     = xi_r ^ x_rd;
    case (state_r)
      S_WMUL: m_start = 1'b1;
      S_EMUL: begin
        m_start = 1'b1;
        m_b     = pos_r ^ x_rd;
      end
      S_INV: begin
        m_start = 1'b1;
        m_a     = ph_r ? r_r : sq_r;
        m_b     = sq_r;
      end
      S_EY: begin
        m_start = 1'b1;
        m_a     = y_rd;
        m_b     = t_r;
      end
      default: m_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      modulus_r <= ModulusReset;
      count_r   <= '0;
      cur_r     <= 1'b0;
      dup_r     <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            modulus_r <= cfg_data;
          end
          if (in_valid) begin
            req_r   <= in_data;
            pos_r   <= in_data.position;
            state_r <= S_WRD;
          end
        end
        S_WRD: begin
          state_r <= S_IDLE;
          case (req_r.operation)
            OP_CLEAR: begin
              count_r <= '0;
              cur_r   <= 1'b0;
              dup_r   <= 1'b0;
              ovf_r   <= 1'b0;
            end
            OP_LOAD: begin
              if (load_ok) begin
                count_r <= count_r + 1'b1;
                cur_r   <= 1'b0;
              end else begin
                ovf_r <= 1'b1;
              end
            end
            OP_EVAL: begin
              i_r     <= '0;
              acc_r   <= '0;
              state_r <= cur_r ? S_EI : S_WI;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_WI: begin
          if (i_r == count_r) begin
            cur_r   <= 1'b1;
            i_r     <= '0;
            state_r <= S_EI;
          end else begin
            t_r     <= FieldWidth'(1);
            j_r     <= '0;
            k_r     <= '0;
            state_r <= S_WJ;
          end
        end
        S_WJ: begin
          if (j_r == '0) begin
            xi_r <= x_rd;
          end
          if (j_r == count_r) begin
            if (t_r == '0) begin
              dup_r <= 1'b1;
            end
            sq_r    <= t_r;
            r_r     <= FieldWidth'(1);
            k_r     <= KW'(1);
            ph_r    <= 1'b0;
            state_r <= S_INV;
          end else begin
            state_r <= S_WJD;
          end
        end
        S_WJD: begin
          if (j_r == i_r) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_WJ;
          end else begin
            state_r <= S_WMUL;
          end
        end
        S_WMUL: state_r <= S_INVW;
        S_INV:  state_r <= S_INVW;
        S_INVW: begin
          if (m_done) begin
            if (k_r == '0) begin
              t_r     <= m_p;
              j_r     <= j_r + 1'b1;
              state_r <= S_WJ;
            end else if (!ph_r) begin
              sq_r    <= m_p;
              ph_r    <= 1'b1;
              state_r <= S_INV;
            end else if (k_r == KW'(31)) begin
              i_r     <= i_r + 1'b1;
              state_r <= S_WI;
            end else begin
              r_r     <= m_p;
              ph_r    <= 1'b0;
              k_r     <= k_r + 1'b1;
              state_r <= S_INV;
            end
          end
        end
        S_EI: begin
          if (i_r == count_r) begin
            state_r <= S_OUT;
          end else begin
            j_r     <= '0;
            state_r <= S_EJ;
          end
        end
        S_EJ: begin
          if (j_r == '0) begin
            t_r <= w_rd;
          end
          if (j_r == count_r) begin
            state_r <= S_EY;
          end else begin
            state_r <= S_EJD;
          end
        end
        S_EJD: begin
          if (j_r == i_r) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_EJ;
          end else begin
            state_r <= S_EMUL;
          end
        end
        S_EMUL: state_r <= S_EYW;
        S_EY:   state_r <= S_EYW;
        S_EYW: begin
          if (m_done) begin
            if (j_r == count_r) begin
              acc_r   <= acc_r ^ m_p;
              i_r     <= i_r + 1'b1;
              state_r <= S_EI;
            end else begin
              t_r     <= m_p;
              j_r     <= j_r + 1'b1;
              state_r <= S_EJ;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The weight multiply loop reuses S_INVW with k_r cleared as a marker.
endmodule
`default_nettype wire

### bench/gfli_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfli_checker: result checker for the GF(2^32) Lagrange interpolator
// Watches the request, result and modulus channels, keeps its own copy of the
// point store, predicts every evaluation and compares each result in order.
// ----------------------------------------------------------------------------
module gfli_checker
  import gfli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  gfli_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  gfli_out_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [FieldWidth-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    evals_pending,
  output int                    evals_seen
);
  localparam int Slots = DefMaxPoints;

  logic [FieldWidth-1:0] modulus;
  logic [FieldWidth-1:0] xs [Slots];
  logic [FieldWidth-1:0] ys [Slots];
  logic [FieldWidth-1:0] ws [Slots];
  int                    npoints;
  logic                  weights_ok;
  logic                  dup_flag;
  logic                  ovf_flag;
  gfli_out_t             expected_evals [$];

  function automatic logic [31:0] field_mul(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] m);
    logic [63:0] p;
    p = '0;
    for (int k = 0; k < 32; k++) begin
      if (b[k]) p ^= {32'b0, a} << k;
    end
    for (int k = 63; k >= 32; k--) begin
      if (p[k]) p ^= (64'b1 << k) ^ ({32'b0, m} << (k - 32));
    end
    return p[31:0];
  endfunction

  function automatic logic [31:0] field_inv(logic [31:0] a, logic [31:0] m);
    logic [31:0] sq;
    logic [31:0] r;
    sq = a;
    r = 32'd1;
    for (int k = 1; k < 32; k++) begin
      sq = field_mul(sq, sq, m);
      r = field_mul(r, sq, m);
    end
    return r;
  endfunction

  task automatic refresh_weights();
    logic [31:0] t;
    for (int i = 0; i < npoints; i++) begin
      t = 32'd1;
      for (int j = 0; j < npoints; j++) begin
        if (i != j) t = field_mul(t, xs[i] ^ xs[j], modulus);
      end
      if (t == 32'd0) dup_flag = 1'b1;
      ws[i] = field_inv(t, modulus);
    end
    weights_ok = 1'b1;
  endtask

  task automatic apply_request(gfli_in_t r);
    gfli_out_t   e;
    logic [31:0] acc;
    logic [31:0] v;
    case (r.operation)
      OP_CLEAR: begin
        npoints = 0;
        weights_ok = 1'b0;
        dup_flag = 1'b0;
        ovf_flag = 1'b0;
      end
      OP_LOAD: begin
        if (npoints < Slots) begin
          xs[npoints] = r.point_x;
          ys[npoints] = r.point_y;
          npoints++;
          weights_ok = 1'b0;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      OP_EVAL: begin
        if (!weights_ok) refresh_weights();
        acc = '0;
        for (int i = 0; i < npoints; i++) begin
          v = ws[i];
          for (int j = 0; j < npoints; j++) begin
            if (i != j) v = field_mul(v, r.position ^ xs[j], modulus);
          end
          acc ^= field_mul(ys[i], v, modulus);
        end
        e.value = acc;
        e.duplicate_nodes = dup_flag;
        e.overflowed = ovf_flag;
        expected_evals.push_back(e);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    gfli_out_t e;
    if (!rst_n) begin
      modulus <= ModulusReset;
      npoints = 0;
      weights_ok = 1'b0;
      dup_flag = 1'b0;
      ovf_flag = 1'b0;
      expected_evals.delete();
      mismatch_count <= 0;
      evals_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) modulus <= cfg_data;
      if (in_valid && in_ready) apply_request(in_data);
      if (out_valid && out_ready) begin
        evals_seen <= evals_seen + 1;
        if (expected_evals.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result %h", $realtime, out_data);
          mismatch_count <= mismatch_count + 1;
        end else begin
          e = expected_evals.pop_front();
          if (e != out_data) begin
            if (mismatch_count < 10)
              $display("%0t: expected value %h dup %b ovf %b, got %h dup %b ovf %b",
                       $realtime, e.value, e.duplicate_nodes, e.overflowed,
                       out_data.value, out_data.duplicate_nodes,
                       out_data.overflowed);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    evals_pending <= expected_evals.size();
  end
endmodule

### bench/tb_gf2_32_lagrange_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gf2_32_lagrange_interpolator: testbench for the GF(2^32) interpolator
// Drives directed and random request sequences in bursts, stalls the result
// side, changes the field modulus between phases and reports the verdict.
// ----------------------------------------------------------------------------
module tb_gf2_32_lagrange_interpolator;
  import gfli_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  gfli_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  gfli_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [FieldWidth-1:0] cfg_data = '0;
  int                    mismatch_count;
  int                    evals_pending;
  int                    evals_seen;
  int                    burst_left = 0;
  int                    sent = 0;
  logic [31:0]           last_x;

  gf2_32_lagrange_interpolator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  gfli_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .evals_pending(evals_pending),
    .evals_seen(evals_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    bit held;
    int mode;
    held = 0;
    mode = 0;
    wait (rst_n);
    forever begin
      if (!held && evals_seen >= 2) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        held = 1;
      end else begin
        if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic gfli_in_t mk(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                  logic [31:0] p);
    gfli_in_t r;
    r.operation = op;
    r.point_x = x;
    r.point_y = y;
    r.position = p;
    return r;
  endfunction

  task automatic send_request(gfli_in_t r);
    bit rdy;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= r;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    if (r.operation != 2'd3) sent++;
  endtask

  task automatic idle_bus();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic write_modulus(logic [31:0] m);
    bit rdy;
    idle_bus();
    wait (evals_pending == 0);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_sequence(bit full);
    int n;
    int sel;
    logic [31:0] x;
    if (full || $urandom_range(0, 9) != 0) send_request(mk(OP_CLEAR, $urandom, $urandom,
                                                           $urandom));
    sel = $urandom_range(0, 19);
    if (full) n = 16 + $urandom_range(1, 2);
    else if (sel < 3) n = 0;
    else if (sel < 17) n = $urandom_range(1, 3);
    else n = $urandom_range(4, 6);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0 && i > 0) x = last_x;
      else if (sel == 1) x = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
      else x = $urandom;
      last_x = x;
      send_request(mk(OP_LOAD, x, $urandom, $urandom));
    end
    if ($urandom_range(0, 19) == 0) send_request(mk(2'd3, $urandom, $urandom, $urandom));
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      x = ($urandom_range(0, 4) == 0) ? last_x : $urandom;
      send_request(mk(OP_EVAL, $urandom, $urandom, x));
    end
  endtask

  task automatic random_phase(int items, int full_at);
    int seq;
    int start;
    seq = 0;
    start = sent;
    while (sent - start < items) begin
      random_sequence(seq == full_at);
      seq++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(mk(OP_EVAL, 0, 0, 32'h0));
    send_request(mk(OP_LOAD, 32'h0, 32'hFFFFFFFF, 0));
    send_request(mk(OP_LOAD, 32'hFFFFFFFF, 32'h0, 0));
    send_request(mk(OP_EVAL, 0, 0, 32'h0));
    send_request(mk(OP_EVAL, 0, 0, 32'hFFFFFFFF));
    send_request(mk(OP_EVAL, 0, 0, 32'h12345678));
    send_request(mk(OP_LOAD, 32'h0, 32'h5, 0));
    send_request(mk(OP_EVAL, 0, 0, 32'h1));
    send_request(mk(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_request(mk(OP_EVAL, 0, 0, 32'h2));
    send_request(mk(OP_CLEAR, 0, 0, 0));
    send_request(mk(OP_EVAL, 0, 0, 32'hFFFFFFFF));
    send_request(mk(OP_LOAD, 32'h1, 32'h1, 0));
    send_request(mk(OP_EVAL, 0, 0, 32'h1));
    send_request(mk(OP_LOAD, 32'h80000000, 32'hAAAAAAAA, 0));
    send_request(mk(OP_EVAL, 0, 0, 32'h55555555));

    random_phase(120, 5);
    write_modulus(32'hFFFFFFFF);
    random_phase(90, -1);
    write_modulus(32'h0);
    random_phase(90, 3);
    write_modulus($urandom);
    random_phase(90, -1);
    write_modulus(ModulusReset);
    random_phase(90, -1);

    idle_bus();
    wait (evals_pending == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && evals_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
